@@ rtl/core/orhc_pkg.sv @@
// Shared constants for the ONC RPC header checker.
package orhc_pkg;

  // Width of the byte counter and of the wire length.
  localparam int unsigned LengthBits = 16;

  // Minimum lengths and the word size, in bytes.
  localparam int unsigned MinHeader  = 12;
  localparam int unsigned MinCall    = 40;
  localparam int unsigned WordBytes  = 4;

  // Largest legal auth flavor and rejection code, and the required RPC version.
  localparam logic [31:0] FlavorMax  = 32'd3;
  localparam logic [31:0] RejectMax  = 32'd1;
  localparam logic [31:0] RpcVersion = 32'd2;

  // Message type and reply status words.
  localparam logic [31:0] MsgCall       = 32'd0;
  localparam logic [31:0] MsgReply      = 32'd1;
  localparam logic [31:0] ReplyAccepted = 32'd0;
  localparam logic [31:0] ReplyDenied   = 32'd1;

  // Verdict codes.
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StErr   = 2'd1;
  localparam logic [1:0] StShort = 2'd2;

  // Message kind codes.
  localparam logic KindCall  = 1'b0;
  localparam logic KindReply = 1'b1;

  // Parser phases.
  localparam logic [4:0] PhStart   = 5'd0;
  localparam logic [4:0] PhFrag    = 5'd1;
  localparam logic [4:0] PhXid     = 5'd2;
  localparam logic [4:0] PhType    = 5'd3;
  localparam logic [4:0] PhBadType = 5'd4;
  localparam logic [4:0] PhVers    = 5'd5;
  localparam logic [4:0] PhProg    = 5'd6;
  localparam logic [4:0] PhPver    = 5'd7;
  localparam logic [4:0] PhProc    = 5'd8;
  localparam logic [4:0] PhCflav   = 5'd9;
  localparam logic [4:0] PhClen    = 5'd10;
  localparam logic [4:0] PhCbody   = 5'd11;
  localparam logic [4:0] PhVflav   = 5'd12;
  localparam logic [4:0] PhVlen    = 5'd13;
  localparam logic [4:0] PhVbody   = 5'd14;
  localparam logic [4:0] PhRstat   = 5'd15;
  localparam logic [4:0] PhRej     = 5'd16;
  localparam logic [4:0] PhDone    = 5'd17;

endpackage

@@ rtl/core/onc_rpc_header_checker.sv @@
// ONC RPC v2 message header checker, one payload byte per transfer.
//
// Payload bytes enter one per transfer; the byte flagged last_byte_i closes the
// packet and yields exactly one verdict transfer (parse status, message kind and
// the call/reply header words). Over TCP (from_tcp_i, sampled on the first byte)
// a 4-byte record mark is skipped, then the transaction id; the big-endian
// message type selects the call path (rpc version must be 2, then program,
// program version, procedure, credential and verifier with flavor 0..3 and
// bodies skipped by length) or the reply path (accepted: verifier; denied:
// rejection code 0..1). wire_bytes_i is sampled on the last byte: under 12
// bytes is a parse error, as is a call under 40 bytes; a capture ending before
// the header is complete reports too short. Bytes after a complete header are
// ignored. Throughput is one byte per cycle unless the input stalls; from input
// transfer to verdict, an input register feeds the parser state update, whose
// verdict lands in an output register. The input side only
// stalls when a last byte is waiting and the output register is full and
// stalled. All parser state returns to its reset values after each verdict.
module onc_rpc_header_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [orhc_pkg::LengthBits-1:0] wire_bytes_i,
  input  logic        from_tcp_i,
  // verdict output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  parse_status_o,
  output logic        message_kind_o,
  output logic [31:0] rpc_vers_o,
  output logic [31:0] program_number_o,
  output logic [31:0] prog_vers_o,
  output logic [31:0] procedure_number_o,
  output logic [31:0] reply_state_o
);

  localparam int unsigned LB = orhc_pkg::LengthBits;
  localparam logic [LB-1:0] CountMax = {LB{1'b1}};

  // input register
  logic          s1_valid_q;
  logic [7:0]    s1_byte_q;
  logic          s1_last_q;
  logic [LB-1:0] s1_wire_q;
  logic          s1_tcp_q;

  // parser state
  logic [4:0]    phase_q, phase_d;
  logic [LB-1:0] count_q, count_d;
  logic [31:0]   word_q, word_d;
  logic [31:0]   skip_q, skip_d;
  logic [1:0]    status_q, status_d;
  logic          kind_q, kind_d;
  logic [31:0]   version_q, version_d;
  logic [31:0]   program_q, program_d;
  logic [31:0]   progver_q, progver_d;
  logic [31:0]   procedure_q, procedure_d;
  logic [31:0]   reply_q, reply_d;

  // output register
  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic          out_kind_q;
  logic [31:0]   out_version_q, out_program_q, out_progver_q;
  logic [31:0]   out_procedure_q, out_reply_q;

  logic proc_fire;
  logic out_load;
  logic in_accept;
  logic [1:0] verdict;

  // A non-last byte never needs the output register.
  assign proc_fire = s1_valid_q && (!s1_last_q || !out_valid_q || !out_stall_i);
  assign out_load  = proc_fire && s1_last_q;
  assign in_stall_o = s1_valid_q && !proc_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Per-byte parser step
  logic [4:0]  ph;
  logic [31:0] sk_in, wd_in, sk_dec, w;

  always_comb begin
    phase_d     = phase_q;
    skip_d      = skip_q;
    word_d      = word_q;
    status_d    = status_q;
    kind_d      = kind_q;
    version_d   = version_q;
    program_d   = program_q;
    progver_d   = progver_q;
    procedure_d = procedure_q;
    reply_d     = reply_q;

    // first byte of a packet picks the entry point
    if (phase_q == orhc_pkg::PhStart) begin
      ph    = s1_tcp_q ? orhc_pkg::PhFrag : orhc_pkg::PhXid;
      sk_in = 32'(orhc_pkg::WordBytes);
      wd_in = '0;
    end else begin
      ph    = phase_q;
      sk_in = skip_q;
      wd_in = word_q;
    end
    w      = {wd_in[23:0], s1_byte_q};
    sk_dec = (sk_in != '0) ? sk_in - 32'd1 : sk_in;

    count_d = (count_q < CountMax) ? count_q + 1'b1 : count_q;

    if (ph == orhc_pkg::PhDone || ph == orhc_pkg::PhBadType) begin
      phase_d = ph;
      skip_d  = sk_in;
      word_d  = wd_in;
    end else if (sk_dec != '0) begin
      phase_d = ph;
      skip_d  = sk_dec;
      word_d  = w;
    end else begin
      // word or skipped body complete: default is to enter the next field
      skip_d = 32'(orhc_pkg::WordBytes);
      word_d = '0;
      unique case (ph)
        orhc_pkg::PhFrag: phase_d = orhc_pkg::PhXid;
        orhc_pkg::PhXid:  phase_d = orhc_pkg::PhType;
        orhc_pkg::PhType: begin
          if (w == orhc_pkg::MsgCall) begin
            kind_d  = orhc_pkg::KindCall;
            phase_d = orhc_pkg::PhVers;
          end else if (w == orhc_pkg::MsgReply) begin
            kind_d  = orhc_pkg::KindReply;
            phase_d = orhc_pkg::PhRstat;
          end else begin
            phase_d = orhc_pkg::PhBadType;
            skip_d  = '0;
            word_d  = w;
          end
        end
        orhc_pkg::PhVers: begin
          version_d = w;
          if (w != orhc_pkg::RpcVersion) begin
            status_d = orhc_pkg::StErr;
            phase_d  = orhc_pkg::PhDone;
          end else begin
            phase_d = orhc_pkg::PhProg;
          end
        end
        orhc_pkg::PhProg: begin
          program_d = w;
          phase_d   = orhc_pkg::PhPver;
        end
        orhc_pkg::PhPver: begin
          progver_d = w;
          phase_d   = orhc_pkg::PhProc;
        end
        orhc_pkg::PhProc: begin
          procedure_d = w;
          phase_d     = orhc_pkg::PhCflav;
        end
        orhc_pkg::PhCflav: begin
          if (w > orhc_pkg::FlavorMax) begin
            status_d = orhc_pkg::StErr;
            phase_d  = orhc_pkg::PhDone;
          end else begin
            phase_d = orhc_pkg::PhClen;
          end
        end
        orhc_pkg::PhClen: begin
          if (w == '0) begin
            phase_d = orhc_pkg::PhVflav;
          end else begin
            phase_d = orhc_pkg::PhCbody;
            skip_d  = w;
          end
        end
        orhc_pkg::PhCbody: phase_d = orhc_pkg::PhVflav;
        orhc_pkg::PhVflav: begin
          if (w > orhc_pkg::FlavorMax) begin
            status_d = orhc_pkg::StErr;
            phase_d  = orhc_pkg::PhDone;
          end else begin
            phase_d = orhc_pkg::PhVlen;
          end
        end
        orhc_pkg::PhVlen: begin
          if (w == '0) begin
            status_d = orhc_pkg::StOk;
            phase_d  = orhc_pkg::PhDone;
          end else begin
            phase_d = orhc_pkg::PhVbody;
            skip_d  = w;
          end
        end
        orhc_pkg::PhVbody: begin
          status_d = orhc_pkg::StOk;
          phase_d  = orhc_pkg::PhDone;
        end
        orhc_pkg::PhRstat: begin
          reply_d = w;
          if (w == orhc_pkg::ReplyAccepted) begin
            phase_d = orhc_pkg::PhVflav;
          end else if (w == orhc_pkg::ReplyDenied) begin
            phase_d = orhc_pkg::PhRej;
          end else begin
            status_d = orhc_pkg::StOk;
            phase_d  = orhc_pkg::PhDone;
          end
        end
        orhc_pkg::PhRej: begin
          status_d = (w > orhc_pkg::RejectMax) ? orhc_pkg::StErr : orhc_pkg::StOk;
          phase_d  = orhc_pkg::PhDone;
        end
        default: begin
          phase_d = ph;
          skip_d  = sk_dec;
          word_d  = w;
        end
      endcase
    end
  end

  // Verdict at the last byte, checked in priority order
  always_comb begin
    priority if (s1_wire_q < LB'(orhc_pkg::MinHeader)) begin
      verdict = orhc_pkg::StErr;
    end else if (count_d < LB'(orhc_pkg::MinHeader)) begin
      verdict = orhc_pkg::StShort;
    end else if (phase_d == orhc_pkg::PhBadType) begin
      verdict = orhc_pkg::StErr;
    end else if (kind_d == orhc_pkg::KindCall && s1_wire_q < LB'(orhc_pkg::MinCall)) begin
      verdict = orhc_pkg::StErr;
    end else if (kind_d == orhc_pkg::KindCall && count_d < LB'(orhc_pkg::MinCall)) begin
      verdict = orhc_pkg::StShort;
    end else if (phase_d == orhc_pkg::PhDone) begin
      verdict = status_d;
    end else begin
      verdict = orhc_pkg::StShort;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (proc_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
      s1_wire_q <= wire_bytes_i;
      s1_tcp_q  <= from_tcp_i;
    end
  end

  // Parser state; the last byte returns everything to the packet start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= orhc_pkg::PhStart;
      count_q     <= '0;
      word_q      <= '0;
      skip_q      <= '0;
      status_q    <= orhc_pkg::StOk;
      kind_q      <= orhc_pkg::KindCall;
      version_q   <= '0;
      program_q   <= '0;
      progver_q   <= '0;
      procedure_q <= '0;
      reply_q     <= '0;
    end else if (out_load) begin
      phase_q     <= orhc_pkg::PhStart;
      count_q     <= '0;
      word_q      <= '0;
      skip_q      <= '0;
      status_q    <= orhc_pkg::StOk;
      kind_q      <= orhc_pkg::KindCall;
      version_q   <= '0;
      program_q   <= '0;
      progver_q   <= '0;
      procedure_q <= '0;
      reply_q     <= '0;
    end else if (proc_fire) begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      word_q      <= word_d;
      skip_q      <= skip_d;
      status_q    <= status_d;
      kind_q      <= kind_d;
      version_q   <= version_d;
      program_q   <= program_d;
      progver_q   <= progver_d;
      procedure_q <= procedure_d;
      reply_q     <= reply_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q    <= verdict;
      out_kind_q      <= (verdict == orhc_pkg::StOk) ? kind_d : orhc_pkg::KindCall;
      out_version_q   <= version_d;
      out_program_q   <= program_d;
      out_progver_q   <= progver_d;
      out_procedure_q <= procedure_d;
      out_reply_q     <= reply_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign parse_status_o     = out_status_q;
  assign message_kind_o     = out_kind_q;
  assign rpc_vers_o         = out_version_q;
  assign program_number_o   = out_program_q;
  assign prog_vers_o        = out_progver_q;
  assign procedure_number_o = out_procedure_q;
  assign reply_state_o      = out_reply_q;

`ifndef SYNTHESIS
  // a last byte always leaves the parser at packet start
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (phase_q == orhc_pkg::PhStart && count_q == '0))
    else $error("parser not reset after last byte");

  // only ok verdicts carry a reply kind
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != orhc_pkg::StOk) |-> out_kind_q == orhc_pkg::KindCall)
    else $error("message kind set on failed verdict");

  // only the three defined verdict codes
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_status_q == orhc_pkg::StOk || out_status_q == orhc_pkg::StErr ||
                     out_status_q == orhc_pkg::StShort))
    else $error("illegal verdict code");

  // phase stays within the defined range
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= orhc_pkg::PhDone)
    else $error("phase out of range");

  // input only stalls behind a blocked last byte
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_last_q && out_valid_q && out_stall_i))
    else $error("unexpected input stall");
`endif

endmodule
